FILE: hw/rtl/fpd_pkg.sv
// Shared types and constants for the flight phase detector.
`default_nettype none

package fpd_pkg;

  localparam int SAMPLE_W = 24;
  localparam int THR_W    = 20;
  localparam int CFG_IDX_W = 2;
  localparam int DIFF_W   = SAMPLE_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_LAUNCH_RISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_APOGEE_DROP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LANDED_BAND = 2'd2;

  localparam logic [THR_W-1:0] LAUNCH_RISE_RST = 20'd1600;
  localparam logic [THR_W-1:0] APOGEE_DROP_RST = 20'd80;
  localparam logic [THR_W-1:0] LANDED_BAND_RST = 20'd80;

  typedef enum logic [1:0] {
    PHASE_PAD     = 2'd0,
    PHASE_ASCENT  = 2'd1,
    PHASE_DESCENT = 2'd2,
    PHASE_LANDED  = 2'd3
  } phase_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EVAL = 1'b1
  } ctrl_e;

  typedef struct packed {
    logic capture;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fpd_in_if.sv
// Input channel carrying one altitude sample item.
`default_nettype none

interface fpd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [fpd_pkg::SAMPLE_W-1:0] altitude_sample;

  modport source (output valid, output altitude_sample, input ready);
  modport sink   (input valid, input altitude_sample, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/fpd_out_if.sv
// Output channel carrying one flight phase result item.
`default_nettype none

interface fpd_out_if;
  logic                 valid;
  logic                 ready;
  fpd_pkg::phase_e      flight_phase;
  logic                 phase_changed;

  modport source (output valid, output flight_phase, output phase_changed, input ready);
  modport sink   (input valid, input flight_phase, input phase_changed, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/fpd_cell.sv
// One window cell: holds one altitude entry, compares it to the sample, shifts toward the oldest.
`default_nettype none

module fpd_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fpd_pkg::cell_ctrl_t                 ctrl_i,
  input  logic signed [fpd_pkg::SAMPLE_W-1:0] shift_data_i,
  input  logic signed [fpd_pkg::SAMPLE_W-1:0] sample_i,
  input  logic        [fpd_pkg::THR_W-1:0]    launch_rise_i,
  input  logic        [fpd_pkg::THR_W-1:0]    apogee_drop_i,
  output logic signed [fpd_pkg::SAMPLE_W-1:0] entry_o,
  output logic                                rise_hit_o,
  output logic                                drop_hit_o
);
  import fpd_pkg::*;

  logic signed [SAMPLE_W-1:0] entry_q, entry_d;
  logic                       rise_q, rise_d;
  logic                       drop_q, drop_d;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [DIFF_W-1:0]   rise_ext;
  logic signed [DIFF_W-1:0]   drop_neg;

  always_comb begin
    diff     = DIFF_W'(sample_i) - DIFF_W'(entry_q);
    rise_ext = $signed({{(DIFF_W-THR_W){1'b0}}, launch_rise_i});
    drop_neg = -$signed({{(DIFF_W-THR_W){1'b0}}, apogee_drop_i});
  end

  always_comb begin
    entry_d = ctrl_i.shift ? shift_data_i : entry_q;
    rise_d  = ctrl_i.capture ? (diff > rise_ext) : rise_q;
    drop_d  = ctrl_i.capture ? (diff < drop_neg) : drop_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      rise_q  <= 1'b0;
      drop_q  <= 1'b0;
    end else begin
      entry_q <= entry_d;
      rise_q  <= rise_d;
      drop_q  <= drop_d;
    end
  end

  assign entry_o    = entry_q;
  assign rise_hit_o = rise_q;
  assign drop_hit_o = drop_q;

endmodule

`default_nettype wire

FILE: hw/rtl/flight_phase_detector.sv
// Flight phase detector: row of window cells plus phase tracking and result register.
// Items are taken one at a time: no new sample is accepted until EVAL finishes, which
// waits for a free result register. Capture registers the per-cell compares; finish
// reduces the cell flags, advances the phase and shifts the cell row unless landed.
// Reset: window entries clear to zero, phase to pad, thresholds to 1600/80/80.
`default_nettype none

module flight_phase_detector #(
  parameter int WINDOW_DEPTH = 40
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic        [fpd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic        [fpd_pkg::THR_W-1:0]     cfg_data_i,
  fpd_in_if.sink                               sample_in,
  fpd_out_if.source                            result_out
);
  import fpd_pkg::*;

  logic [THR_W-1:0] launch_rise_q, apogee_drop_q, landed_band_q;

  ctrl_e  state_q, state_d;
  phase_e phase_q, phase_d;
  logic   out_free, finish, in_ready;
  logic   hit;

  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [SAMPLE_W-1:0] entry_w [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0]    rise_flags, drop_flags;
  cell_ctrl_t                 cell_ctrl;

  logic signed [DIFF_W-1:0] land_diff;
  logic        [DIFF_W-1:0] land_abs;
  logic                     near_oldest;

  logic   out_valid_q;
  phase_e out_phase_q;
  logic   out_changed_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_rise_q <= LAUNCH_RISE_RST;
      apogee_drop_q <= APOGEE_DROP_RST;
      landed_band_q <= LANDED_BAND_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LAUNCH_RISE: launch_rise_q <= cfg_data_i;
        REG_APOGEE_DROP: apogee_drop_q <= cfg_data_i;
        REG_LANDED_BAND: landed_band_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (sample_in.valid) state_d = ST_EVAL;
      ST_EVAL: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    out_free = !out_valid_q || result_out.ready;
    in_ready = 1'b0;
    finish   = 1'b0;
    case (state_q)
      ST_IDLE: in_ready = 1'b1;
      ST_EVAL: finish   = out_free;
      default: ;
    endcase
    cell_ctrl.capture = in_ready && sample_in.valid;
    // freeze the window once landed
    cell_ctrl.shift   = finish && (phase_q != PHASE_LANDED);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_ctrl.capture) begin
      sample_q <= sample_in.altitude_sample;
    end
  end

  // Cell row: entry 0 oldest, newest enters at the top end
  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    logic signed [SAMPLE_W-1:0] shift_src;
    if (i == WINDOW_DEPTH - 1) begin : g_top
      assign shift_src = sample_q;
    end else begin : g_mid
      assign shift_src = entry_w[i+1];
    end
    fpd_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (cell_ctrl),
      .shift_data_i  (shift_src),
      .sample_i      (sample_in.altitude_sample),
      .launch_rise_i (launch_rise_q),
      .apogee_drop_i (apogee_drop_q),
      .entry_o       (entry_w[i]),
      .rise_hit_o    (rise_flags[i]),
      .drop_hit_o    (drop_flags[i])
    );
  end

  always_comb begin
    land_diff   = DIFF_W'(entry_w[0]) - DIFF_W'(sample_q);
    land_abs    = land_diff[DIFF_W-1] ? DIFF_W'(-land_diff) : DIFF_W'(land_diff);
    near_oldest = land_abs < {{(DIFF_W-THR_W){1'b0}}, landed_band_q};
  end

  always_comb begin
    case (phase_q)
      PHASE_PAD:     hit = |rise_flags;
      PHASE_ASCENT:  hit = |drop_flags;
      PHASE_DESCENT: hit = near_oldest;
      default:       hit = 1'b0;
    endcase
    phase_d = phase_q;
    if (finish && hit) begin
      phase_d = phase_e'(phase_q + 2'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PHASE_PAD;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (result_out.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result payload until the next item finishes
  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_phase_q   <= phase_d;
      out_changed_q <= hit;
    end
  end

  assign sample_in.ready          = in_ready;
  assign result_out.valid         = out_valid_q;
  assign result_out.flight_phase  = out_phase_q;
  assign result_out.phase_changed = out_changed_q;

`ifndef SYNTHESIS
  a_landed_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PHASE_LANDED |=> phase_q == PHASE_LANDED)
    else $error("phase left landed");

  a_phase_steps_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != $past(phase_q) |-> phase_q == 2'($past(phase_q) + 2'd1))
    else $error("phase moved by other than one step");

  a_window_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PHASE_LANDED |=> $stable(entry_w[WINDOW_DEPTH-1]))
    else $error("window changed after landing");

  a_finish_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_valid_q && state_q == ST_IDLE)
    else $error("finished item produced no result");
`endif

endmodule

`default_nettype wire
